// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Implication checked every clock, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- src/lcs_pkg.sv -----
// ----------------------------------------------------------------------------
// Link connect supervisor package
// Types, codes and reset values shared by the supervisor and its interfaces.
// ----------------------------------------------------------------------------
package lcs_pkg;

    localparam int TIME_W    = 32;
    localparam int TAG_W     = 32;
    localparam int MS_W      = 20;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = MS_W;

    typedef enum logic [1:0] {
        MODE_IDLE       = 2'd0,
        MODE_WAIT       = 2'd1,
        MODE_CONNECTING = 2'd2,
        MODE_CONNECTED  = 2'd3
    } mode_t;

    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_LINK_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BT_MODE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SSID_PRESENT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_MS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GRACE_MS      = 3'd5;

    localparam logic [MS_W-1:0] RETRY_MS_RST   = 20'd5000;
    localparam logic [MS_W-1:0] TIMEOUT_MS_RST = 20'd10000;
    localparam logic [MS_W-1:0] GRACE_MS_RST   = 20'd15000;

    typedef struct packed {
        logic              command;
        logic [TIME_W-1:0] now_ms;
        logic              link_up;
        logic [TAG_W-1:0]  request_tag;
    } cmd_item_t;

    typedef struct packed {
        logic       stop_radio;
        logic       restart_radio;
        logic       start_connect;
        logic       drop_attempt;
        logic       connected_event;
        logic [1:0] link_mode;
        logic       link_ok;
    } res_item_t;

endpackage

// ----- src/lcs_cmd_if.sv -----
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying ticks and connect requests.
// ----------------------------------------------------------------------------
interface lcs_cmd_if;
    logic                 valid;
    logic                 ready;
    lcs_pkg::cmd_item_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/lcs_res_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one supervisor result per command.
// ----------------------------------------------------------------------------
interface lcs_res_if;
    logic                 valid;
    logic                 ready;
    lcs_pkg::res_item_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/link_connect_supervisor.sv -----
// ----------------------------------------------------------------------------
// Link connect supervisor
// Idle / wait-retry / connecting / connected mode control for a radio link.
// ----------------------------------------------------------------------------
// Path: input register, then result register; a stalled result holds the item.
// Throughput: 1 item per cycle unless res.ready stalls; the mode update is a
// single pass of subtract/compare logic between the input and result registers.
// Reset: mode idle, timestamps and tag cleared, config at 5000/10000/15000 ms,
// enable, bluetooth and ssid flags off; both channels empty.
`include "assert_macros.svh"

module link_connect_supervisor (
    input  logic                            clk,
    input  logic                            rst_n,
    lcs_cmd_if.sink                         cmd,
    lcs_res_if.source                       res,
    input  logic                            cfg_we,
    input  logic [lcs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lcs_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // configuration
    logic                       link_enable_reg;
    logic                       bt_mode_reg;
    logic                       ssid_present_reg;
    logic [lcs_pkg::MS_W-1:0]   retry_ms_reg;
    logic [lcs_pkg::MS_W-1:0]   timeout_ms_reg;
    logic [lcs_pkg::MS_W-1:0]   grace_ms_reg;

    // supervisor state
    lcs_pkg::mode_t               mode_reg, mode_next, mode_mid;
    logic [lcs_pkg::TIME_W-1:0]   entered_time_reg, entered_time_next;
    logic [lcs_pkg::TIME_W-1:0]   attempt_time_reg, attempt_time_next;
    logic [lcs_pkg::TIME_W-1:0]   lost_time_reg, lost_time_next;
    logic                         lost_pending_reg, lost_pending_next;
    logic                         retry_now_reg, retry_now_next;
    logic [lcs_pkg::TAG_W-1:0]    last_tag_reg, last_tag_next;

    // pipeline
    logic                 in_valid_reg;
    lcs_pkg::cmd_item_t   in_data_reg;
    logic                 res_valid_reg;
    lcs_pkg::res_item_t   res_data_reg;
    lcs_pkg::res_item_t   res_next;

    logic out_free;
    logic proc;
    logic cmd_fire;

    logic [lcs_pkg::TIME_W-1:0] lost_age;
    logic [lcs_pkg::TIME_W-1:0] attempt_age;
    logic [lcs_pkg::TIME_W-1:0] entered_age;
    logic                       sched_block;
    logic                       wait_due;

    assign out_free  = !res_valid_reg || res.ready;
    assign proc      = in_valid_reg && out_free;
    assign cmd.ready = !in_valid_reg || out_free;
    assign cmd_fire  = cmd.valid && cmd.ready;

    assign res.valid = res_valid_reg;
    assign res.data  = res_data_reg;

    assign lost_age    = in_data_reg.now_ms - lost_time_reg;
    assign attempt_age = in_data_reg.now_ms - attempt_time_reg;
    assign entered_age = in_data_reg.now_ms - entered_time_reg;
    assign sched_block = !link_enable_reg || bt_mode_reg || !ssid_present_reg;

    always_comb
    begin
        mode_next         = mode_reg;
        mode_mid          = mode_reg;
        entered_time_next = entered_time_reg;
        attempt_time_next = attempt_time_reg;
        lost_time_next    = lost_time_reg;
        lost_pending_next = lost_pending_reg;
        retry_now_next    = retry_now_reg;
        last_tag_next     = last_tag_reg;
        wait_due          = 1'b0;
        res_next          = '0;

        if (in_data_reg.command == lcs_pkg::CMD_REQUEST)
        begin
            if (sched_block)
            begin
                if (mode_reg != lcs_pkg::MODE_IDLE)
                begin
                    res_next.stop_radio = 1'b1;
                    mode_next           = lcs_pkg::MODE_IDLE;
                end
            end
            else if (!(mode_reg == lcs_pkg::MODE_CONNECTING &&
                       in_data_reg.request_tag == last_tag_reg))
            begin
                last_tag_next  = in_data_reg.request_tag;
                mode_next      = lcs_pkg::MODE_WAIT;
                retry_now_next = 1'b1;
            end
        end
        else if (bt_mode_reg)
        begin
            if (mode_reg != lcs_pkg::MODE_IDLE)
            begin
                res_next.stop_radio = 1'b1;
                mode_next           = lcs_pkg::MODE_IDLE;
            end
        end
        else
        begin
            // link loss supervision
            priority if (mode_reg != lcs_pkg::MODE_CONNECTED || in_data_reg.link_up)
            begin
                lost_pending_next = 1'b0;
            end
            else if (!lost_pending_reg)
            begin
                lost_pending_next = 1'b1;
                lost_time_next    = in_data_reg.now_ms;
            end
            else if (lost_age >= lcs_pkg::TIME_W'(grace_ms_reg))
            begin
                res_next.restart_radio = 1'b1;
                lost_pending_next      = 1'b0;
                mode_mid               = lcs_pkg::MODE_WAIT;
                entered_time_next      = in_data_reg.now_ms;
                retry_now_next         = 1'b0;
                attempt_time_next      = in_data_reg.now_ms -
                                         lcs_pkg::TIME_W'(retry_ms_reg);
            end
            else
            begin
            end

            mode_next = mode_mid;
            // after a forced restart the wait is always due, and the attempt time is backdated
            wait_due  = res_next.restart_radio || retry_now_reg ||
                        (attempt_age >= lcs_pkg::TIME_W'(retry_ms_reg));

            unique case (mode_mid)
                lcs_pkg::MODE_WAIT:
                begin
                    if (wait_due)
                    begin
                        if (!ssid_present_reg)
                        begin
                            mode_next = lcs_pkg::MODE_IDLE;
                        end
                        else
                        begin
                            res_next.start_connect = 1'b1;
                            mode_next              = lcs_pkg::MODE_CONNECTING;
                            entered_time_next      = in_data_reg.now_ms;
                            attempt_time_next      = in_data_reg.now_ms;
                            retry_now_next         = 1'b0;
                        end
                    end
                end
                lcs_pkg::MODE_CONNECTING:
                begin
                    if (in_data_reg.link_up)
                    begin
                        mode_next                = lcs_pkg::MODE_CONNECTED;
                        lost_pending_next        = 1'b0;
                        res_next.connected_event = 1'b1;
                    end
                    else if (entered_age >= lcs_pkg::TIME_W'(timeout_ms_reg))
                    begin
                        res_next.drop_attempt = 1'b1;
                        mode_next             = lcs_pkg::MODE_WAIT;
                        entered_time_next     = in_data_reg.now_ms;
                        attempt_time_next     = in_data_reg.now_ms;
                        retry_now_next        = 1'b0;
                    end
                end
                lcs_pkg::MODE_IDLE, lcs_pkg::MODE_CONNECTED:
                begin
                end
                default:
                begin
                end
            endcase
        end

        res_next.link_mode = mode_next;
        res_next.link_ok   = (mode_next == lcs_pkg::MODE_CONNECTED) && in_data_reg.link_up;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_enable_reg  <= 1'b0;
            bt_mode_reg      <= 1'b0;
            ssid_present_reg <= 1'b0;
            retry_ms_reg     <= lcs_pkg::RETRY_MS_RST;
            timeout_ms_reg   <= lcs_pkg::TIMEOUT_MS_RST;
            grace_ms_reg     <= lcs_pkg::GRACE_MS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lcs_pkg::CFG_LINK_ENABLE:  link_enable_reg  <= cfg_data[0];
                lcs_pkg::CFG_BT_MODE:      bt_mode_reg      <= cfg_data[0];
                lcs_pkg::CFG_SSID_PRESENT: ssid_present_reg <= cfg_data[0];
                lcs_pkg::CFG_RETRY_MS:     retry_ms_reg     <= cfg_data[lcs_pkg::MS_W-1:0];
                lcs_pkg::CFG_TIMEOUT_MS:   timeout_ms_reg   <= cfg_data[lcs_pkg::MS_W-1:0];
                lcs_pkg::CFG_GRACE_MS:     grace_ms_reg     <= cfg_data[lcs_pkg::MS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= lcs_pkg::MODE_IDLE;
            entered_time_reg <= '0;
            attempt_time_reg <= '0;
            lost_time_reg    <= '0;
            lost_pending_reg <= 1'b0;
            retry_now_reg    <= 1'b0;
            last_tag_reg     <= '0;
            in_valid_reg     <= 1'b0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (proc)
            begin
                in_valid_reg <= 1'b0;
            end

            if (proc)
            begin
                res_valid_reg    <= 1'b1;
                mode_reg         <= mode_next;
                entered_time_reg <= entered_time_next;
                attempt_time_reg <= attempt_time_next;
                lost_time_reg    <= lost_time_next;
                lost_pending_reg <= lost_pending_next;
                retry_now_reg    <= retry_now_next;
                last_tag_reg     <= last_tag_next;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            in_data_reg <= cmd.data;
        end
        if (proc)
        begin
            res_data_reg <= res_next;
        end
    end

    `ASSERT_IMPLY(a_stop_alone, clk, rst_n,
        res_valid_reg && res_data_reg.stop_radio,
        !res_data_reg.start_connect && !res_data_reg.restart_radio &&
        !res_data_reg.drop_attempt && !res_data_reg.connected_event &&
        res_data_reg.link_mode == lcs_pkg::MODE_IDLE,
        "stop with other event")
    `ASSERT_IMPLY(a_ok_mode, clk, rst_n,
        res_valid_reg && res_data_reg.link_ok,
        res_data_reg.link_mode == lcs_pkg::MODE_CONNECTED,
        "link_ok outside connected")
    `ASSERT_IMPLY(a_conn_mode, clk, rst_n,
        res_valid_reg && res_data_reg.connected_event,
        res_data_reg.link_mode == lcs_pkg::MODE_CONNECTED,
        "connected event wrong mode")
    `ASSERT_IMPLY(a_drop_mode, clk, rst_n,
        res_valid_reg && res_data_reg.drop_attempt,
        res_data_reg.link_mode == lcs_pkg::MODE_WAIT,
        "drop not back to wait")
    `ASSERT_NEXT(a_state_hold, clk, rst_n, !proc,
        mode_reg == $past(mode_reg) && retry_now_reg == $past(retry_now_reg),
        "state moved without item")

endmodule
